// ===== rtl/int4_dequant_l2_distance_assert.svh =====
// Assertion macros for the int4 dequantizing squared L2 distance block
`ifndef INT4_DEQUANT_L2_DISTANCE_ASSERT_SVH
`define INT4_DEQUANT_L2_DISTANCE_ASSERT_SVH

// Concurrent check, quiet while reset is asserted
`define I4DQL2_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds across reset
`define I4DQL2_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/i4dql2_pkg.sv =====
// Shared constants, types and a helper function for the int4 L2 distance block
`default_nettype none

package i4dql2_pkg;

    // Fixed field widths
    localparam int DATA_W   = 32;
    localparam int CODE_W   = 8;
    localparam int NIB_W    = 4;
    localparam int SUM_W    = 63;

    // Fixed-point fraction bits (Q16.16 by default, 8..24 supported)
    localparam int FRAC_BITS = 16;

    // Magnitude of one difference and its exact square
    localparam int ABS_W    = 33;
    localparam int AL_W     = 17;
    localparam int AH_W     = ABS_W - AL_W;
    localparam int SQ_W     = 2 * ABS_W;
    localparam int TERM_W   = SQ_W - FRAC_BITS;

    // Reciprocal of 15 for 32-bit dividends: q = (x * RECIP15) >> RECIP15_SHIFT
    localparam logic [DATA_W-1:0] RECIP15 = 32'h8888_8889;
    localparam int RECIP15_SHIFT = 35;
    localparam int QUOT_W = 2 * DATA_W - RECIP15_SHIFT;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic sel_b;
        logic acc_en;
        logic emit;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic second_valid;
        logic last;
    } dp_status_t;

    // floor(v / 15) for v below 240
    function automatic logic [NIB_W-1:0] div15_small(input logic [7:0] v);
        logic [12:0] prod;
        prod = ({5'b0, v} + 13'd1) * 13'd17;
        return prod[11:8];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/i4dql2_ctrl.sv =====
// Sequencing state machine for the int4 L2 distance block
`default_nettype none

module i4dql2_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    input  wire i4dql2_pkg::dp_status_t  status,
    output i4dql2_pkg::ctrl_cmd_t        cmd
);
    import i4dql2_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DIFF,
        ST_SQR,
        ST_ACC,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   sel_b_reg, sel_b_next;
    logic   m_valid_reg, m_valid_next;

    logic   accept;
    logic   emit;

    assign accept  = s_valid && (state_reg == ST_IDLE);
    assign emit    = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // Drive datapath commands
    always_comb begin
        cmd.capture = accept;
        cmd.sel_b   = sel_b_reg;
        cmd.acc_en  = (state_reg == ST_ACC);
        cmd.emit    = emit;
    end

    // Advance through one dimension pass, repeat for the second when second_valid is set, then emit on a last item
    always_comb begin
        state_next   = state_reg;
        sel_b_next   = sel_b_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    sel_b_next = 1'b0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  state_next = ST_DIFF;
            ST_DIFF: state_next = ST_SQR;
            ST_SQR:  state_next = ST_ACC;
            ST_ACC: begin
                if (!sel_b_reg && status.second_valid) begin
                    sel_b_next = 1'b1;
                    state_next = ST_MUL;
                end else if (status.last) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (emit) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sel_b_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sel_b_reg   <= sel_b_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/i4dql2_dpath.sv =====
// Dequantize, difference, square and saturating accumulate datapath
`default_nettype none

module i4dql2_dpath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire i4dql2_pkg::ctrl_cmd_t               cmd,
    output i4dql2_pkg::dp_status_t                   status,
    input  wire logic [i4dql2_pkg::CODE_W-1:0]       in_code_byte,
    input  wire logic signed [i4dql2_pkg::DATA_W-1:0] in_query_a,
    input  wire logic signed [i4dql2_pkg::DATA_W-1:0] in_query_b,
    input  wire logic signed [i4dql2_pkg::DATA_W-1:0] in_offset_a,
    input  wire logic signed [i4dql2_pkg::DATA_W-1:0] in_offset_b,
    input  wire logic signed [i4dql2_pkg::DATA_W-1:0] in_span_a,
    input  wire logic signed [i4dql2_pkg::DATA_W-1:0] in_span_b,
    input  wire logic                                in_second_valid,
    input  wire logic                                in_last,
    output logic [i4dql2_pkg::SUM_W-1:0]             distance
);
    import i4dql2_pkg::*;

    // Captured item
    logic [CODE_W-1:0]        code_reg;
    logic signed [DATA_W-1:0] query_a_reg, query_b_reg;
    logic signed [DATA_W-1:0] offset_a_reg, offset_b_reg;
    logic signed [DATA_W-1:0] span_a_reg, span_b_reg;
    logic                     second_reg, last_reg;

    // Stage 1: reciprocal multiply
    logic [NIB_W-1:0]         nib_sel;
    logic signed [DATA_W-1:0] span_sel;
    logic [DATA_W-1:0]        sabs;
    logic [2*DATA_W-1:0]      recip_prod;
    logic [NIB_W-1:0]         nib_reg;
    logic                     sneg_reg;
    logic [DATA_W-1:0]        sabs_reg;
    logic [QUOT_W-1:0]        quot_reg;

    // Stage 2: scaled magnitude
    logic [DATA_W:0]          rem_wide;
    logic [NIB_W-1:0]         rem;
    logic [7:0]               nib_rem;
    logic [DATA_W:0]          nib_quot;
    logic [DATA_W-1:0]        mag_next;
    logic [DATA_W-1:0]        mag_reg;
    logic                     sneg2_reg;

    // Stage 3: difference magnitude
    logic signed [DATA_W-1:0] query_sel, offset_sel;
    logic signed [DATA_W+1:0] scaled;
    logic signed [DATA_W+2:0] diff;
    logic [DATA_W+2:0]        diff_abs;
    logic [ABS_W-1:0]         abs_reg;

    // Stage 4: partial products
    logic [AH_W-1:0]          a_hi;
    logic [AL_W-1:0]          a_lo;
    logic [2*AH_W-1:0]        pp_hh_reg;
    logic [AH_W+AL_W-1:0]     pp_hl_reg;
    logic [2*AL_W-1:0]        pp_ll_reg;

    // Accumulate
    logic [SQ_W-1:0]          square;
    logic [TERM_W-1:0]        term;
    logic [SUM_W:0]           sum_wide;
    logic [SUM_W-1:0]         sum_sat;
    logic [SUM_W-1:0]         sum_reg;
    logic [SUM_W-1:0]         distance_reg;

    assign status.second_valid = second_reg;
    assign status.last         = last_reg;
    assign distance            = distance_reg;

    // Capture item on input transfer
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            code_reg     <= in_code_byte;
            query_a_reg  <= in_query_a;
            query_b_reg  <= in_query_b;
            offset_a_reg <= in_offset_a;
            offset_b_reg <= in_offset_b;
            span_a_reg   <= in_span_a;
            span_b_reg   <= in_span_b;
            second_reg   <= in_second_valid;
            last_reg     <= in_last;
        end
    end

    // Select the dimension and multiply |span| by the reciprocal of 15
    always_comb begin
        nib_sel    = cmd.sel_b ? code_reg[NIB_W-1:0] : code_reg[CODE_W-1:NIB_W];
        span_sel   = cmd.sel_b ? span_b_reg : span_a_reg;
        sabs       = span_sel[DATA_W-1] ? (~span_sel + 1'b1) : span_sel;
        recip_prod = {{DATA_W{1'b0}}, sabs} * {{DATA_W{1'b0}}, RECIP15};
    end

    always_ff @(posedge aclk) begin
        nib_reg  <= nib_sel;
        sneg_reg <= span_sel[DATA_W-1];
        sabs_reg <= sabs;
        quot_reg <= recip_prod[2*DATA_W-1:RECIP15_SHIFT];
    end

    // nib * |span| / 15 = nib * q + floor(nib * r / 15), with |span| = 15q + r
    always_comb begin
        rem_wide = {1'b0, sabs_reg} - {quot_reg, 4'b0} + {4'b0, quot_reg};
        rem      = rem_wide[NIB_W-1:0];
        nib_rem  = {4'b0, nib_reg} * {4'b0, rem};
        nib_quot = {{(DATA_W+1-NIB_W){1'b0}}, nib_reg} * {4'b0, quot_reg};
        mag_next = nib_quot[DATA_W-1:0] + {{(DATA_W-NIB_W){1'b0}}, div15_small(nib_rem)};
    end

    always_ff @(posedge aclk) begin
        mag_reg   <= mag_next;
        sneg2_reg <= sneg_reg;
    end

    // Form query - (offset + scaled) and take its magnitude
    always_comb begin
        query_sel  = cmd.sel_b ? query_b_reg : query_a_reg;
        offset_sel = cmd.sel_b ? offset_b_reg : offset_a_reg;
        scaled     = sneg2_reg ? -$signed({2'b0, mag_reg}) : $signed({2'b0, mag_reg});
        diff       = {{3{query_sel[DATA_W-1]}}, query_sel}
                   - {{3{offset_sel[DATA_W-1]}}, offset_sel}
                   - {scaled[DATA_W+1], scaled};
        diff_abs   = diff[DATA_W+2] ? -diff : diff;
    end

    always_ff @(posedge aclk) begin
        abs_reg <= diff_abs[ABS_W-1:0];
    end

    // Split the square into three narrow partial products
    assign a_hi = abs_reg[ABS_W-1:AL_W];
    assign a_lo = abs_reg[AL_W-1:0];

    always_ff @(posedge aclk) begin
        pp_hh_reg <= {{AH_W{1'b0}}, a_hi} * {{AH_W{1'b0}}, a_hi};
        pp_hl_reg <= {{AL_W{1'b0}}, a_hi} * {{AH_W{1'b0}}, a_lo};
        pp_ll_reg <= {{AL_W{1'b0}}, a_lo} * {{AL_W{1'b0}}, a_lo};
    end

    // Combine, drop fraction bits and add with saturation
    always_comb begin
        square   = {pp_hh_reg, {(2*AL_W){1'b0}}}
                 + {{(SQ_W-AH_W-2*AL_W-1){1'b0}}, pp_hl_reg, {(AL_W+1){1'b0}}}
                 + {{(SQ_W-2*AL_W){1'b0}}, pp_ll_reg};
        term     = square[SQ_W-1:FRAC_BITS];
        sum_wide = {1'b0, sum_reg} + {{(SUM_W+1-TERM_W){1'b0}}, term};
        sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (cmd.emit) begin
            sum_reg <= '0;
        end else if (cmd.acc_en) begin
            sum_reg <= sum_sat;
        end
    end

    // Load the result register on emit
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            distance_reg <= sum_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/int4_dequant_l2_distance.sv =====
// Top level of the int4 dequantizing squared L2 distance block
// Each transfer carries one packed code byte (two 4-bit dimensions) with the
// query, offset and span of both dimensions in signed Q16.16. Each dimension is
// dequantized as offset + trunc(nibble * span / 15), subtracted from the query,
// squared exactly, shifted back to Q16.16 and added to a 63-bit accumulator
// that saturates at its maximum. The byte flagged last emits the total on m_
// and clears the accumulator. Items are processed one at a time through a
// five-stage dimension datapath that handles one dimension per pass: an item
// passes the MUL, DIV, DIFF, SQR and ACC states for the first dimension,
// again for the second when second_valid is set, and on a last byte goes
// through EMIT to load the result register (held there while the previous
// result is still waiting to be taken) before the next item is accepted.
// Results wait in an output register, so new items are accepted while a result is pending.
`default_nettype none

module int4_dequant_l2_distance (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [i4dql2_pkg::CODE_W-1:0]        s_code_byte,
    input  wire logic signed [i4dql2_pkg::DATA_W-1:0] s_query_a,
    input  wire logic signed [i4dql2_pkg::DATA_W-1:0] s_query_b,
    input  wire logic signed [i4dql2_pkg::DATA_W-1:0] s_offset_a,
    input  wire logic signed [i4dql2_pkg::DATA_W-1:0] s_offset_b,
    input  wire logic signed [i4dql2_pkg::DATA_W-1:0] s_span_a,
    input  wire logic signed [i4dql2_pkg::DATA_W-1:0] s_span_b,
    input  wire logic                                 s_second_valid,
    input  wire logic                                 s_last,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [i4dql2_pkg::SUM_W-1:0]              m_distance
);
    import i4dql2_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    i4dql2_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    i4dql2_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .in_code_byte    (s_code_byte),
        .in_query_a      (s_query_a),
        .in_query_b      (s_query_b),
        .in_offset_a     (s_offset_a),
        .in_offset_b     (s_offset_b),
        .in_span_a       (s_span_a),
        .in_span_b       (s_span_b),
        .in_second_valid (s_second_valid),
        .in_last         (s_last),
        .distance        (m_distance)
    );

endmodule

`default_nettype wire

// ===== rtl/i4dql2_checker.sv =====
// Port-level checker for the int4 L2 distance block, bound to the top level
`default_nettype none

`include "int4_dequant_l2_distance_assert.svh"

module i4dql2_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          s_last,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [i4dql2_pkg::SUM_W-1:0]  m_distance
);
    import i4dql2_pkg::*;

    // A stalled result holds its value
    `I4DQL2_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_distance), "result changed while stalled")

    // One item at a time: input stalls right after a transfer
    `I4DQL2_ASSERT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready, "input taken while busy")

    // A byte without last never raises a result the next cycle
    `I4DQL2_ASSERT(a_no_early_result, aclk, aresetn, s_valid && s_ready && !s_last |=> !$rose(m_valid), "result raised without last")

    // Reset leaves no result pending
    `I4DQL2_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind int4_dequant_l2_distance i4dql2_checker u_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_last     (s_last),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_distance (m_distance)
);

`default_nettype wire
